>>> rtl/qeb_pkg.sv
// Package for the quadrature encoder with button: field widths, the quadrature
// transition decode and the constants for division by counts per step.
// Has no dependencies; used by every module in the rtl folder.
package qeb_pkg;

   localparam int COUNTS_PER_STEP = 2;

   localparam int CNT_W   = 16;
   localparam int MAG_W   = CNT_W + 1;
   localparam int STEPS_W = 15;
   localparam int TICKS_W = 24;

   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = TICKS_W'(10000);

   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
   localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
   localparam logic signed [MAG_W-1:0] STEPS_MAX = 17'sd16383;
   localparam logic signed [MAG_W-1:0] STEPS_MIN = -17'sd16383;

   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((2 ** DIV_SHIFT) + COUNTS_PER_STEP - 1) / COUNTS_PER_STEP);

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_UP,
      MOVE_DOWN,
      MOVE_BAD
   } move_type;

   // Transition code is old A, old B, new A, new B.
   function automatic move_type quad_decode(input logic [3:0] code);
      move_type mv;
      case (code)
         4'b0001, 4'b0111, 4'b1000, 4'b1110: mv = MOVE_UP;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: mv = MOVE_DOWN;
         4'b0011, 4'b0110, 4'b1001, 4'b1100: mv = MOVE_BAD;
         default:                            mv = MOVE_NONE;
      endcase
      return mv;
   endfunction

endpackage

>>> rtl/quadrature_encoder_with_button.sv
// Quadrature encoder decoder with debounced push button, top level.
// A beat accepted under rsp_stall waits in the skid register. Throughput:
// one beat per cycle unless stalled; the decode, count update, division and
// debounce all sit between the request port and the response register.
// Synchronous active-high reset clears the count and flags, sets the button
// level to released and the debounce setting to 10000 ticks.
module quadrature_encoder_with_button
   import qeb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TICKS_W-1:0]        csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_pin_a,
   input  logic                      req_pin_b,
   input  logic                      req_pin_button,
   input  logic                      req_clear_steps,
   input  logic                      req_clear_button,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [STEPS_W-1:0] rsp_steps,
   output logic                      rsp_button_pressed
);

   logic [TICKS_W-1:0]        ticks_ff;
   logic signed [CNT_W-1:0]   count_ff, count_in, count_mid;
   logic                      prev_a_ff, prev_b_ff, primed_ff, prev_btn_ff;
   logic [TICKS_W-1:0]        timer_ff, timer_in, timer_dec;
   logic                      running_ff, running_in;
   logic                      flag_ff, flag_in, flag_mid;
   logic                      out_valid_ff, out_valid_in;
   logic signed [STEPS_W-1:0] out_steps_ff, out_steps_in;
   logic                      out_flag_ff, out_flag_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic signed [STEPS_W-1:0] skid_steps_ff;
   logic                      skid_flag_ff;
   logic                      accept, take;
   move_type                  move;
   logic signed [MAG_W-1:0]   quot;
   logic signed [CNT_W-1:0]   rem;
   logic signed [STEPS_W-1:0] res_steps;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = out_valid_ff & ~rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_steps          = out_steps_ff;
   assign rsp_button_pressed = out_flag_ff;

   qeb_step_div u_div (
      .count (count_mid),
      .quot  (quot),
      .rem   (rem)
   );

   always_comb begin
      move      = quad_decode({prev_a_ff, prev_b_ff, req_pin_a, req_pin_b});
      count_mid = count_ff;
      if (primed_ff) begin
         if (move == MOVE_UP && count_ff != CNT_MAX) begin
            count_mid = count_ff + 16'sd1;
         end else if (move == MOVE_DOWN && count_ff != CNT_MIN) begin
            count_mid = count_ff - 16'sd1;
         end
      end

      timer_dec  = timer_ff - TICKS_W'(1);
      timer_in   = timer_ff;
      running_in = running_ff;
      flag_mid   = flag_ff;
      if (req_pin_button != prev_btn_ff) begin
         timer_in   = (ticks_ff == '0) ? TICKS_W'(1) : ticks_ff;
         running_in = 1'b1;
      end else if (running_ff) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            running_in = 1'b0;
            if (!req_pin_button) begin
               flag_mid = 1'b1;
            end
         end
      end

      if (quot > STEPS_MAX) begin
         res_steps = STEPS_W'(STEPS_MAX);
      end else if (quot < STEPS_MIN) begin
         res_steps = STEPS_W'(STEPS_MIN);
      end else begin
         res_steps = STEPS_W'(quot);
      end

      count_in = (req_clear_steps && quot != '0) ? rem : count_mid;
      flag_in  = flag_mid & ~req_clear_button;
   end

   // Output register with a one-beat skid stage behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_steps_in  = out_steps_ff;
      out_flag_in   = out_flag_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_steps_in  = skid_steps_ff;
            out_flag_in   = skid_flag_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_steps_in = res_steps;
            out_flag_in  = flag_mid;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff      <= DEBOUNCE_RESET;
         count_ff      <= '0;
         prev_a_ff     <= 1'b0;
         prev_b_ff     <= 1'b0;
         primed_ff     <= 1'b0;
         prev_btn_ff   <= 1'b1;
         timer_ff      <= '0;
         running_ff    <= 1'b0;
         flag_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ticks_ff <= csr_data;
         end
         if (accept) begin
            count_ff    <= count_in;
            prev_a_ff   <= req_pin_a;
            prev_b_ff   <= req_pin_b;
            primed_ff   <= 1'b1;
            prev_btn_ff <= req_pin_button;
            timer_ff    <= timer_in;
            running_ff  <= running_in;
            flag_ff     <= flag_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_steps_ff <= out_steps_in;
      out_flag_ff  <= out_flag_in;
      if (accept && out_valid_ff && !take) begin
         skid_steps_ff <= res_steps;
         skid_flag_ff  <= flag_mid;
      end
   end

endmodule

>>> rtl/qeb_step_div.sv
// Divides the position count by counts per step, truncating toward zero,
// with a reciprocal multiplication; also returns the signed remainder.
// Depends on qeb_pkg.
module qeb_step_div
   import qeb_pkg::*;
(
   input  logic signed [CNT_W-1:0] count,
   output logic signed [MAG_W-1:0] quot,
   output logic signed [CNT_W-1:0] rem
);

   logic                          neg;
   logic signed [MAG_W-1:0]       count_ext;
   logic        [MAG_W-1:0]       mag;
   logic        [MAG_W+RECIP_W-1:0] prod;
   logic        [MAG_W-1:0]       q_mag;
   logic        [MAG_W-1:0]       r_mag;

   always_comb begin
      neg       = count[CNT_W-1];
      count_ext = {count[CNT_W-1], count};
      mag       = neg ? MAG_W'(-count_ext) : MAG_W'(count_ext);
      prod      = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(DIV_RECIP);
      q_mag     = prod[DIV_SHIFT +: MAG_W];
      r_mag     = mag - MAG_W'(q_mag * MAG_W'(COUNTS_PER_STEP));
      quot      = neg ? -$signed(q_mag) : $signed(q_mag);
      rem       = neg ? CNT_W'(-$signed(r_mag)) : CNT_W'($signed(r_mag));
   end

endmodule

>>> verif/quadrature_encoder_with_button_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for quadrature_encoder_with_button: directed and random ticks
// are checked against a cycle-free model of the decoder, counter and button debounce.
// Depends on qeb_pkg and the quadrature_encoder_with_button RTL only.
module quadrature_encoder_with_button_test;
   import qeb_pkg::*;

   typedef struct packed {
      logic a;
      logic b;
      logic btn;
      logic clr_steps;
      logic clr_btn;
   } tick_type;

   typedef struct packed {
      logic signed [STEPS_W-1:0] steps;
      logic                      pressed;
   } report_type;

   localparam int IDLE_LIMIT = 1000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [TICKS_W-1:0]        csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_pin_a = 1'b0;
   logic                      req_pin_b = 1'b0;
   logic                      req_pin_button = 1'b1;
   logic                      req_clear_steps = 1'b0;
   logic                      req_clear_button = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [STEPS_W-1:0] rsp_steps;
   logic                      rsp_button_pressed;

   // Model state of the block.
   int                 count_m;
   logic               last_a, last_b, primed_m, btn_level_m;
   logic [TICKS_W-1:0] timer_m, ticks_m;
   logic               running_m, pressed_m;

   report_type  pending_reports[$];
   int          error_count = 0;
   int          gap_max = 15;
   int          rsp_hold = 0;
   int          idle_cycles = 0;
   logic [1:0]  enc_phase = 2'd0;
   logic        btn_drive = 1'b1;
   int          btn_run = 0;

   quadrature_encoder_with_button uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pin_a          (req_pin_a),
      .req_pin_b          (req_pin_b),
      .req_pin_button     (req_pin_button),
      .req_clear_steps    (req_clear_steps),
      .req_clear_button   (req_clear_button),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_steps          (rsp_steps),
      .rsp_button_pressed (rsp_button_pressed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      return (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
   endfunction

   task automatic reset_model();
      count_m     = 0;
      last_a      = 1'b0;
      last_b      = 1'b0;
      primed_m    = 1'b0;
      btn_level_m = 1'b1;
      timer_m     = '0;
      ticks_m     = DEBOUNCE_RESET;
      running_m   = 1'b0;
      pressed_m   = 1'b0;
   endtask

   // The A/B pair is a Gray code; its phase {A, A^B} advances by one per count up.
   task automatic decode_tick(input tick_type t);
      report_type r;
      logic [1:0] turn;
      move_type   mv;
      int         quot;
      int         clamped;
      if (primed_m) begin
         turn = {t.a, t.a ^ t.b} - {last_a, last_a ^ last_b};
         mv = (turn == 2'd1) ? MOVE_UP : (turn == 2'd3) ? MOVE_DOWN :
              (turn == 2'd2) ? MOVE_BAD : MOVE_NONE;
         case (mv)
            MOVE_UP: begin
               if (count_m < int'(CNT_MAX)) count_m++;
            end
            MOVE_DOWN: begin
               if (count_m > int'(CNT_MIN)) count_m--;
            end
            default: ;
         endcase
      end else begin
         primed_m = 1'b1;
      end
      last_a = t.a;
      last_b = t.b;

      if (t.btn != btn_level_m) begin
         timer_m   = (ticks_m == '0) ? TICKS_W'(1) : ticks_m;
         running_m = 1'b1;
      end else if (running_m) begin
         timer_m = timer_m - 1'b1;
         if (timer_m == '0) begin
            running_m = 1'b0;
            if (!t.btn) pressed_m = 1'b1;
         end
      end
      btn_level_m = t.btn;

      quot    = count_m / COUNTS_PER_STEP;
      clamped = quot;
      if (clamped > int'(STEPS_MAX)) clamped = int'(STEPS_MAX);
      if (clamped < int'(STEPS_MIN)) clamped = int'(STEPS_MIN);
      r.steps   = STEPS_W'(clamped);
      r.pressed = pressed_m;
      pending_reports.push_back(r);

      if (t.clr_steps && quot != 0) count_m = count_m % COUNTS_PER_STEP;
      if (t.clr_btn) pressed_m = 1'b0;
   endtask

   task automatic send_tick(input tick_type t);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pin_a        <= t.a;
      req_pin_b        <= t.b;
      req_pin_button   <= t.btn;
      req_clear_steps  <= t.clr_steps;
      req_clear_button <= t.clr_btn;
      do @(posedge clock); while (!(req_valid && !req_stall));
      decode_tick(t);
      enc_phase = {t.a, t.a ^ t.b};
   endtask

   // dir is the phase advance: 1 up, -1 down, 0 no move, 2 an illegal jump.
   task automatic move_encoder(input int dir, input logic btn, input logic cs, input logic cb);
      logic [1:0] ph;
      ph = enc_phase + 2'(dir);
      send_tick('{ph[1], ph[1] ^ ph[0], btn, cs, cb});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_debounce(input logic [TICKS_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ticks_m = value;
   endtask

   task automatic button_pattern(input int hold);
      move_encoder(0, 1'b0, 1'b0, 1'b0);
      repeat (hold) move_encoder(0, 1'b0, 1'b0, 1'b0);
      move_encoder(0, 1'b0, 1'b0, 1'b1);
      move_encoder(0, 1'b1, 1'b0, 1'b0);
      repeat (hold) move_encoder(0, 1'b1, 1'b0, 1'b0);
      move_encoder(0, 1'b0, 1'b0, 1'b0);
      move_encoder(0, 1'b1, 1'b0, 1'b0);
      repeat (hold) move_encoder(0, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_encoder_basics();
      gap_max = 15;
      send_tick('{1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
      repeat (5) move_encoder(1, 1'b1, 1'b0, 1'b0);
      repeat (2) move_encoder(0, 1'b1, 1'b0, 1'b0);
      repeat (2) move_encoder(2, 1'b1, 1'b0, 1'b0);
      repeat (3) move_encoder(-1, 1'b1, 1'b0, 1'b0);
      move_encoder(1, 1'b1, 1'b1, 1'b0);
      move_encoder(-1, 1'b1, 1'b1, 1'b0);
      repeat (3) move_encoder(-1, 1'b1, 1'b0, 1'b0);
      move_encoder(0, 1'b1, 1'b1, 1'b0);
      move_encoder(0, 1'b0, 1'b1, 1'b1);
      move_encoder(0, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_default_debounce();
      gap_max = 0;
      repeat (30) move_encoder(0, 1'b0, 1'b0, 1'b0);
      move_encoder(0, 1'b0, 1'b0, 1'b1);
      repeat (30) move_encoder(0, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_count_runs();
      gap_max = 0;
      repeat (60) move_encoder(1, 1'b1, 1'b0, 1'b0);
      move_encoder(0, 1'b1, 1'b1, 1'b0);
      repeat (130) move_encoder(-1, 1'b1, 1'b0, 1'b0);
      move_encoder(0, 1'b1, 1'b1, 1'b0);
      move_encoder(0, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_debounce_settings();
      gap_max = 15;
      write_debounce(TICKS_W'(0));
      button_pattern(2);
      write_debounce(TICKS_W'(1));
      button_pattern(2);
      write_debounce({TICKS_W{1'b1}});
      button_pattern(4);
      write_debounce(TICKS_W'(3));
      button_pattern(1);
      button_pattern(4);
   endtask

   task automatic send_random_tick();
      int   pick;
      int   span;
      logic cs, cb;
      span = (ticks_m > 20) ? 20 : int'(ticks_m);
      if (btn_run == 0) begin
         btn_drive = ~btn_drive;
         btn_run   = $urandom_range(0, 2 * span + 3);
      end else begin
         btn_run--;
      end
      cs   = ($urandom_range(0, 6) == 0);
      cb   = ($urandom_range(0, 6) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         move_encoder($urandom_range(0, 2) != 0 ? 1 : -1, btn_drive, cs, cb);
      else if (pick < 80)
         move_encoder(0, btn_drive, cs, cb);
      else if (pick < 90)
         move_encoder(2, btn_drive, cs, cb);
      else
         send_tick('{1'($urandom), 1'($urandom), btn_drive, cs, cb});
   endtask

   task automatic test_random_traffic();
      logic [TICKS_W-1:0] settings [4];
      int                 gaps [4];
      settings = '{TICKS_W'(2), TICKS_W'(1), TICKS_W'($urandom_range(1, 12)), TICKS_W'(7)};
      gaps     = '{15, 15, 0, 15};
      foreach (settings[i]) begin
         write_debounce(settings[i]);
         gap_max = gaps[i];
         repeat (380) send_random_tick();
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("response beat with no expected report");
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_steps !== want.steps) begin
               $error("steps: expected %0d, got %0d", want.steps, rsp_steps);
               error_count++;
            end
            if (rsp_button_pressed !== want.pressed) begin
               $error("button_pressed: expected %0b, got %0b", want.pressed,
                      rsp_button_pressed);
               error_count++;
            end
         end
         rsp_hold = draw_gap();
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_encoder_basics();
      test_default_debounce();
      test_count_runs();
      test_debounce_settings();
      test_random_traffic();
      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
